/* sv/assert_macros.svh */
// assertion macros for the rtl files
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define DAI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DAI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/dai_pkg.sv */
// types and constants for the decimal ascii to integer converter
// no dependencies
`timescale 1ns / 1ps

package dai_pkg;

    localparam logic [1:0] MODE_U16 = 2'd0;
    localparam logic [1:0] MODE_U32 = 2'd1;
    localparam logic [1:0] MODE_I32 = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
    localparam logic [1:0] STATUS_NONDIGIT = 2'd2;
    localparam logic [1:0] STATUS_TOO_BIG  = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [3:0] COUNT_MAX      = 4'd15;
    localparam logic [3:0] DIGITS_MAX_U16 = 4'd5;
    localparam logic [3:0] DIGITS_MAX_32  = 4'd10;

    localparam logic [35:0] LIMIT_U16 = 36'd65535;
    localparam logic [35:0] LIMIT_U32 = 36'd4294967295;
    localparam logic [35:0] LIMIT_I32 = 36'd2147483647;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } result_item_t;

endpackage

/* sv/decimal_ascii_to_integer_top.sv */
// decimal ascii to integer converter, top level
// depends on dai_pkg and assert_macros.svh
//
//   channel   direction   handshake                     payload
//   char      in          char_valid / char_stall       dai_pkg::char_item_t
//   result    out         result_valid / result_stall   dai_pkg::result_item_t
//
// one character per cycle while no last character is held; a character sits in
// the input register, where the accumulate step (times ten, add, range compare)
// feeds the result register; result_valid rises the cycle after the last char moves on.
// reset clears the string state; the next character starts a new string.
// a last character waits in the input register only while a result is held
// by result_stall; all other characters keep moving.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module decimal_ascii_to_integer_top
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_stall,
    input  dai_pkg::char_item_t    char_data,
    output logic                   result_valid,
    input  logic                   result_stall,
    output dai_pkg::result_item_t  result_data
);

    logic                  in_valid_reg;
    dai_pkg::char_item_t   in_item_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    dai_pkg::result_item_t out_item_reg;
    dai_pkg::result_item_t out_item_next;

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic        neg_reg;
    logic        neg_next;
    logic        bad_reg;
    logic        bad_next;
    logic        ovf_reg;
    logic        ovf_next;
    logic        first_reg;
    logic        first_next;

    logic        pipe_move;
    logic        accept;
    logic [31:0] acc_base;
    logic [3:0]  count_base;
    logic        is_sign;
    logic        is_digit;
    logic [35:0] acc_wide;
    logic [35:0] limit;
    logic        over;
    logic [3:0]  digits_max;

    assign pipe_move = in_valid_reg
        && (!in_item_reg.last_char || !out_valid_reg || !result_stall);
    assign char_stall = in_valid_reg && !pipe_move;
    assign accept = char_valid && !char_stall;

    always_comb
    begin
        mode_next  = first_reg ? in_item_reg.mode : mode_reg;
        acc_base   = first_reg ? 32'd0 : acc_reg;
        count_base = first_reg ? 4'd0 : count_reg;
        neg_next   = first_reg ? 1'b0 : neg_reg;
        bad_next   = first_reg ? 1'b0 : bad_reg;
        ovf_next   = first_reg ? 1'b0 : ovf_reg;

        is_sign  = first_reg && (mode_next == dai_pkg::MODE_I32)
            && (in_item_reg.char_code == dai_pkg::CHAR_MINUS);
        is_digit = (in_item_reg.char_code >= dai_pkg::CHAR_ZERO)
            && (in_item_reg.char_code <= dai_pkg::CHAR_NINE);

        // acc * 10 + digit
        acc_wide = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
            + {32'd0, in_item_reg.char_code[3:0]};

        case (mode_next)
            dai_pkg::MODE_U16: limit = dai_pkg::LIMIT_U16;
            dai_pkg::MODE_I32: limit = dai_pkg::LIMIT_I32;
            default:           limit = dai_pkg::LIMIT_U32;
        endcase
        over = acc_wide > limit;

        acc_next   = acc_base;
        count_next = count_base;
        if (is_sign)
        begin
            neg_next = 1'b1;
        end
        else
        begin
            if (count_base != dai_pkg::COUNT_MAX)
            begin
                count_next = count_base + 4'd1;
            end
            if (is_digit)
            begin
                if (over)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_wide[31:0];
                end
            end
            else
            begin
                bad_next = 1'b1;
            end
        end

        digits_max = (mode_next == dai_pkg::MODE_U16)
            ? dai_pkg::DIGITS_MAX_U16 : dai_pkg::DIGITS_MAX_32;

        out_item_next.value = 32'd0;
        if ((count_next == 4'd0) || (count_next > digits_max))
        begin
            out_item_next.status = dai_pkg::STATUS_BAD_LEN;
        end
        else if (bad_next)
        begin
            out_item_next.status = dai_pkg::STATUS_NONDIGIT;
        end
        else if (ovf_next)
        begin
            out_item_next.status = dai_pkg::STATUS_TOO_BIG;
        end
        else
        begin
            out_item_next.status = dai_pkg::STATUS_OK;
            out_item_next.value  = neg_next ? (32'd0 - acc_next) : acc_next;
        end

        first_next = in_item_reg.last_char;

        if (pipe_move && in_item_reg.last_char)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b1;
            acc_reg       <= 32'd0;
            count_reg     <= 4'd0;
            mode_reg      <= dai_pkg::MODE_U16;
            neg_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (pipe_move)
            begin
                in_valid_reg <= 1'b0;
            end
            if (pipe_move)
            begin
                first_reg <= first_next;
                acc_reg   <= acc_next;
                count_reg <= count_next;
                mode_reg  <= mode_next;
                neg_reg   <= neg_next;
                bad_reg   <= bad_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= char_data;
        end
        if (pipe_move && in_item_reg.last_char)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;

    `DAI_ASSERT(a_error_value_zero, result_valid |-> (result_data.status == dai_pkg::STATUS_OK || result_data.value == 32'd0), "error result with nonzero value")
    `DAI_ASSERT(a_stall_only_on_last, char_stall |-> (in_item_reg.last_char && out_valid_reg && result_stall), "input stalled without a blocked result")
    `DAI_ASSERT(a_last_restarts, (pipe_move && in_item_reg.last_char) |=> (first_reg && result_valid), "last character did not close the string")
    `DAI_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (!result_valid && !char_stall), "busy during reset")

endmodule

/* bench/testbench.sv */
// testbench for decimal_ascii_to_integer_top: directed strings, then random strings
// checked against an in-bench conversion model; depends on dai_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_CHARS = 650;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PERCENT = 15;
    localparam int QUIET_FROM = 300;
    localparam int QUIET_TO = 450;

    typedef struct {
        logic [1:0]  mode;
        string       text;
        bit          known;
        logic [31:0] value;
        logic [1:0]  status;
    } string_case_t;

    typedef struct {
        dai_pkg::char_item_t   item;
        bit                    known;
        dai_pkg::result_item_t want;
        bit                    pause_after;
    } char_plan_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b1;
    logic                  char_valid = 1'b0;
    logic                  char_stall;
    dai_pkg::char_item_t   char_data = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    dai_pkg::result_item_t result_data;

    char_plan_t            char_plan[$];
    dai_pkg::result_item_t expected_conversions[$];
    int                    total_chars = 0;
    int                    chars_accepted = 0;
    int                    mismatch_count = 0;
    int                    quiet_cycles = 0;
    bit                    plan_ready = 1'b0;
    bit                    waiting_for_drain = 1'b0;
    bit                    held_known = 1'b0;
    dai_pkg::result_item_t held_want = '0;
    bit                    held_pause = 1'b0;

    // conversion model state
    logic [31:0]           conv_acc;
    logic [3:0]            conv_count;
    logic [1:0]            conv_mode;
    bit                    conv_negative;
    bit                    conv_bad_char;
    bit                    conv_overflow;
    bit                    conv_at_start = 1'b1;

    string_case_t directed_cases [24] = '{
        '{dai_pkg::MODE_U16, "0",                 1'b1, 32'd0,         dai_pkg::STATUS_OK},
        '{dai_pkg::MODE_U16, "00065",             1'b1, 32'd65,        dai_pkg::STATUS_OK},
        '{dai_pkg::MODE_U16, "65535",             1'b1, 32'd65535,     dai_pkg::STATUS_OK},
        '{dai_pkg::MODE_U16, "65536",             1'b1, 32'd0,     dai_pkg::STATUS_TOO_BIG},
        '{dai_pkg::MODE_U16, "123456",            1'b1, 32'd0,     dai_pkg::STATUS_BAD_LEN},
        '{dai_pkg::MODE_U16, "-5",                1'b1, 32'd0,    dai_pkg::STATUS_NONDIGIT},
        '{dai_pkg::MODE_U16, "9x99999",           1'b1, 32'd0,     dai_pkg::STATUS_BAD_LEN},
        '{dai_pkg::MODE_U16, "7000a",             1'b1, 32'd0,    dai_pkg::STATUS_NONDIGIT},
        '{dai_pkg::MODE_U32, "4294967295",        1'b1, 32'hFFFF_FFFF, dai_pkg::STATUS_OK},
        '{dai_pkg::MODE_U32, "4294967296",        1'b1, 32'd0,     dai_pkg::STATUS_TOO_BIG},
        '{dai_pkg::MODE_U32, "12345678901",       1'b1, 32'd0,     dai_pkg::STATUS_BAD_LEN},
        '{dai_pkg::MODE_U32, "/:",                1'b1, 32'd0,    dai_pkg::STATUS_NONDIGIT},
        '{dai_pkg::MODE_U32, "0000000000",        1'b1, 32'd0,         dai_pkg::STATUS_OK},
        '{dai_pkg::MODE_U32, "99999999999999999", 1'b1, 32'd0,     dai_pkg::STATUS_BAD_LEN},
        '{dai_pkg::MODE_I32, "2147483647",        1'b1, 32'h7FFF_FFFF, dai_pkg::STATUS_OK},
        '{dai_pkg::MODE_I32, "-2147483647",       1'b1, 32'h8000_0001, dai_pkg::STATUS_OK},
        '{dai_pkg::MODE_I32, "-2147483648",       1'b1, 32'd0,     dai_pkg::STATUS_TOO_BIG},
        '{dai_pkg::MODE_I32, "-",                 1'b1, 32'd0,     dai_pkg::STATUS_BAD_LEN},
        '{dai_pkg::MODE_I32, "-0",                1'b1, 32'd0,         dai_pkg::STATUS_OK},
        '{dai_pkg::MODE_I32, "1-2",               1'b1, 32'd0,    dai_pkg::STATUS_NONDIGIT},
        '{dai_pkg::MODE_I32, "--1",               1'b1, 32'd0,    dai_pkg::STATUS_NONDIGIT},
        '{dai_pkg::MODE_I32, "-31415",            1'b0, 32'd0,         dai_pkg::STATUS_OK},
        '{MODE_SPARE,        "4294967295",        1'b1, 32'hFFFF_FFFF, dai_pkg::STATUS_OK},
        '{dai_pkg::MODE_U16, "5",                 1'b1, 32'd5,         dai_pkg::STATUS_OK}
    };

    decimal_ascii_to_integer_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [35:0] mode_limit(input logic [1:0] mode);
        case (mode)
            dai_pkg::MODE_U16: return dai_pkg::LIMIT_U16;
            dai_pkg::MODE_I32: return dai_pkg::LIMIT_I32;
            default:           return dai_pkg::LIMIT_U32;
        endcase
    endfunction

    function automatic logic [3:0] mode_digits(input logic [1:0] mode);
        return (mode == dai_pkg::MODE_U16) ? dai_pkg::DIGITS_MAX_U16 : dai_pkg::DIGITS_MAX_32;
    endfunction

    task automatic convert_char(input dai_pkg::char_item_t ch, output bit produced,
                                output dai_pkg::result_item_t res);
        logic [35:0] next_acc;
        bit          started;
        started = conv_at_start;
        produced = 1'b0;
        res = '0;
        if (conv_at_start)
        begin
            conv_acc = '0;
            conv_count = '0;
            conv_negative = 1'b0;
            conv_bad_char = 1'b0;
            conv_overflow = 1'b0;
            conv_mode = ch.mode;
            conv_at_start = 1'b0;
        end
        if (started && conv_mode == dai_pkg::MODE_I32 && ch.char_code == dai_pkg::CHAR_MINUS)
        begin
            conv_negative = 1'b1;
        end
        else
        begin
            if (conv_count != dai_pkg::COUNT_MAX)
            begin
                conv_count = conv_count + 4'd1;
            end
            if (ch.char_code >= dai_pkg::CHAR_ZERO && ch.char_code <= dai_pkg::CHAR_NINE)
            begin
                next_acc = {4'd0, conv_acc} * 36'd10
                    + 36'(ch.char_code - dai_pkg::CHAR_ZERO);
                if (next_acc > mode_limit(conv_mode))
                begin
                    conv_overflow = 1'b1;
                end
                else
                begin
                    conv_acc = next_acc[31:0];
                end
            end
            else
            begin
                conv_bad_char = 1'b1;
            end
        end
        if (ch.last_char)
        begin
            produced = 1'b1;
            if (conv_count == 4'd0 || conv_count > mode_digits(conv_mode))
            begin
                res.status = dai_pkg::STATUS_BAD_LEN;
            end
            else if (conv_bad_char)
            begin
                res.status = dai_pkg::STATUS_NONDIGIT;
            end
            else if (conv_overflow)
            begin
                res.status = dai_pkg::STATUS_TOO_BIG;
            end
            else
            begin
                res.status = dai_pkg::STATUS_OK;
                res.value = conv_negative ? 32'd0 - conv_acc : conv_acc;
            end
            conv_at_start = 1'b1;
        end
    endtask

    task automatic add_chars(input logic [1:0] mode, input logic [7:0] chars[$],
                             input bit known, input dai_pkg::result_item_t want,
                             input bit pause_after);
        char_plan_t entry;
        for (int i = 0; i < chars.size(); i++)
        begin
            // only the first character's mode should matter
            entry.item.mode = (i == 0) ? mode : 2'($urandom_range(0, 3));
            entry.item.char_code = chars[i];
            entry.item.last_char = (i == chars.size() - 1);
            entry.known = known;
            entry.want = want;
            entry.pause_after = pause_after && entry.item.last_char;
            char_plan.push_back(entry);
            total_chars++;
        end
    endtask

    function automatic void append_text(inout logic [7:0] chars[$], input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            chars.push_back(text[i]);
        end
    endfunction

    task automatic add_random_string();
        logic [7:0] chars[$];
        logic [1:0] mode;
        longint     near;
        int         kind;
        int         len;
        mode = 2'($urandom_range(0, 3));
        kind = $urandom_range(0, 99);
        if (mode == dai_pkg::MODE_I32 && $urandom_range(0, 2) == 0)
        begin
            chars.push_back(dai_pkg::CHAR_MINUS);
        end
        if (kind < 35)
        begin
            len = $urandom_range(1, mode_digits(mode));
            for (int i = 0; i < len; i++)
            begin
                chars.push_back(dai_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        else if (kind < 65)
        begin
            // values around the range limit of the mode
            near = longint'(mode_limit(mode)) + $urandom_range(0, 4) - 2;
            append_text(chars, $sformatf("%0d", near));
        end
        else if (kind < 80)
        begin
            len = $urandom_range(0, 3) + mode_digits(mode);
            if (chars.size() != 0 && $urandom_range(0, 3) == 0)
            begin
                len = 0;
            end
            for (int i = 0; i < len; i++)
            begin
                chars.push_back(dai_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       chars.push_back(dai_pkg::CHAR_MINUS);
                    1:       chars.push_back(8'($urandom_range(0, 255)));
                    default: chars.push_back(dai_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                endcase
            end
        end
        if (chars.size() == 0)
        begin
            chars.push_back(dai_pkg::CHAR_ZERO);
        end
        add_chars(mode, chars, 1'b0, '0, $urandom_range(0, 39) == 0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    initial
    begin
        logic [7:0]            chars[$];
        dai_pkg::result_item_t want;
        int                    target;
        for (int r = 0; r < $size(directed_cases); r++)
        begin
            chars.delete();
            append_text(chars, directed_cases[r].text);
            want.value = directed_cases[r].value;
            want.status = directed_cases[r].status;
            add_chars(directed_cases[r].mode, chars, directed_cases[r].known, want,
                      r == $size(directed_cases) - 1);
        end
        target = total_chars + RANDOM_CHARS;
        while (total_chars < target)
        begin
            add_random_string();
        end
        plan_ready = 1'b1;
    end

    always @(posedge clk)
    begin
        dai_pkg::result_item_t want;
        bit                    produced;
        bit                    moved;
        bit                    quiet;
        if (rst_n)
        begin
            moved = 1'b0;
            if (char_valid && !char_stall)
            begin
                convert_char(char_data, produced, want);
                if (produced)
                begin
                    if (held_known)
                    begin
                        want = held_want;
                    end
                    expected_conversions.push_back(want);
                end
                if (held_pause)
                begin
                    waiting_for_drain = 1'b1;
                end
                chars_accepted++;
                moved = 1'b1;
            end
            if (result_valid && !result_stall)
            begin
                moved = 1'b1;
                if (expected_conversions.size() == 0)
                begin
                    report_mismatch("unexpected result", result_data.value, '0);
                end
                else
                begin
                    want = expected_conversions.pop_front();
                    if (result_data.value !== want.value)
                    begin
                        report_mismatch("value", result_data.value, want.value);
                    end
                    if (result_data.status !== want.status)
                    begin
                        report_mismatch("status", 32'(result_data.status), 32'(want.status));
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;

            // no random idling on either side in this window
            quiet = chars_accepted >= QUIET_FROM && chars_accepted < QUIET_TO;
            result_stall <= !quiet && $urandom_range(0, 99) < IDLE_PERCENT;

            if (!char_valid || !char_stall)
            begin
                if (waiting_for_drain && expected_conversions.size() != 0)
                begin
                    char_valid <= 1'b0;
                end
                else if (!plan_ready || char_plan.size() == 0 ||
                         (!quiet && $urandom_range(0, 99) < IDLE_PERCENT))
                begin
                    waiting_for_drain = 1'b0;
                    char_valid <= 1'b0;
                end
                else
                begin
                    waiting_for_drain = 1'b0;
                    held_known = char_plan[0].known;
                    held_want = char_plan[0].want;
                    held_pause = char_plan[0].pause_after;
                    char_data <= char_plan[0].item;
                    char_valid <= 1'b1;
                    void'(char_plan.pop_front());
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        while (!(plan_ready && chars_accepted == total_chars &&
                 expected_conversions.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
